// ===== rtl/core/lpg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared codes for the line point generator: request opcodes and axis step
// directions.
// ----------------------------------------------------------------------------
package lpg_pkg;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef logic [1:0] dir_t;

  localparam dir_t DIR_NONE = 2'b00;
  localparam dir_t DIR_UP   = 2'b01;
  localparam dir_t DIR_DOWN = 2'b11;

endpackage
`default_nettype wire

// ===== rtl/core/lpg_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_fifo
// Small synchronous queue with full and empty flags decoded from a registered
// count. Used for the request queue and the point queue.
// ----------------------------------------------------------------------------
module lpg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lpg_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_front
// Request decode: works out absolute deltas, step directions and the major
// distance of a start request and packs the request for the queue.
// ----------------------------------------------------------------------------
module lpg_front #(
  parameter int COORD_BITS = 9
) (
  input  wire logic                   op,
  input  wire logic [COORD_BITS-1:0]  start_x,
  input  wire logic [COORD_BITS-1:0]  start_y,
  input  wire logic [COORD_BITS-1:0]  end_x,
  input  wire logic [COORD_BITS-1:0]  end_y,
  input  wire logic [15:0]            line_color,
  output logic [5*COORD_BITS+20:0]    cmd_word
);
  import lpg_pkg::*;

  logic [COORD_BITS-1:0] abs_dcol;
  logic [COORD_BITS-1:0] abs_drow;
  logic [COORD_BITS-1:0] major_len;
  dir_t                  col_dir;
  dir_t                  row_dir;

  always_comb begin
    if (end_x > start_x) begin
      col_dir  = DIR_UP;
      abs_dcol = end_x - start_x;
    end else if (end_x == start_x) begin
      col_dir  = DIR_NONE;
      abs_dcol = '0;
    end else begin
      col_dir  = DIR_DOWN;
      abs_dcol = start_x - end_x;
    end
    if (end_y > start_y) begin
      row_dir  = DIR_UP;
      abs_drow = end_y - start_y;
    end else if (end_y == start_y) begin
      row_dir  = DIR_NONE;
      abs_drow = '0;
    end else begin
      row_dir  = DIR_DOWN;
      abs_drow = start_y - end_y;
    end
    major_len = (abs_dcol > abs_drow) ? abs_dcol : abs_drow;
  end

  assign cmd_word = {op, start_x, start_y, abs_dcol, abs_drow, major_len,
                     col_dir, row_dir, line_color};

endmodule
`default_nettype wire

// ===== rtl/core/lpg_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_engine
// Stepping engine: holds the running line, takes one request a cycle from
// the request queue when the point queue has room and pushes points into it.
// ----------------------------------------------------------------------------
module lpg_engine #(
  parameter int COORD_BITS = 9
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [5*COORD_BITS+20:0]    cmd_word,
  input  wire logic                        cmd_empty,
  output logic                             cmd_pop,
  output logic      [2*COORD_BITS+16:0]    out_word,
  output logic                             out_push,
  input  wire logic                        out_full
);
  import lpg_pkg::*;

  localparam int CB = COORD_BITS;

  function automatic logic [CB-1:0] step_coord(input logic [CB-1:0] c, input dir_t d);
    logic [CB-1:0] r;
    r = c;
    if (d == DIR_UP) begin
      r = c + 1'b1;
    end else if (d == DIR_DOWN) begin
      r = c - 1'b1;
    end
    return r;
  endfunction

  logic          c_op;
  logic [CB-1:0] c_sx, c_sy, c_adc, c_adr, c_maj;
  dir_t          c_cdir, c_rdir;
  logic [15:0]   c_color;

  assign {c_op, c_sx, c_sy, c_adc, c_adr, c_maj, c_cdir, c_rdir, c_color} = cmd_word;

  logic          busy;
  logic [CB-1:0] cur_col, cur_row;
  logic [CB:0]   col_error, row_error;
  logic [CB-1:0] abs_dcol, abs_drow, major_len;
  dir_t          col_dir, row_dir;
  logic [CB:0]   points_left;
  logic [15:0]   held_color;

  logic          is_start, active, last;
  logic [CB-1:0] e_col, e_row, e_adc, e_adr, e_maj;
  dir_t          e_cdir, e_rdir;
  logic [15:0]   e_color;
  logic [CB:0]   col_sum, row_sum, col_error_next, row_error_next, points_left_next;
  logic [CB-1:0] cur_col_next, cur_row_next;

  assign cmd_pop  = !cmd_empty && !out_full;
  assign is_start = (op_t'(c_op) == OP_START);
  assign active   = is_start || busy;
  assign out_push = cmd_pop && active;

  always_comb begin
    e_col   = is_start ? c_sx    : cur_col;
    e_row   = is_start ? c_sy    : cur_row;
    e_adc   = is_start ? c_adc   : abs_dcol;
    e_adr   = is_start ? c_adr   : abs_drow;
    e_maj   = is_start ? c_maj   : major_len;
    e_cdir  = is_start ? c_cdir  : col_dir;
    e_rdir  = is_start ? c_rdir  : row_dir;
    e_color = is_start ? c_color : held_color;
    last    = is_start ? (c_maj == '0) : (points_left == (CB+1)'(1));
    points_left_next = is_start ? {1'b0, c_maj} : points_left - 1'b1;

    col_sum = (is_start ? '0 : col_error) + {1'b0, e_adc};
    row_sum = (is_start ? '0 : row_error) + {1'b0, e_adr};
    col_error_next = col_sum;
    row_error_next = row_sum;
    cur_col_next   = e_col;
    cur_row_next   = e_row;
    if (col_sum > {1'b0, e_maj}) begin
      col_error_next = col_sum - {1'b0, e_maj};
      cur_col_next   = step_coord(e_col, e_cdir);
    end
    if (row_sum > {1'b0, e_maj}) begin
      row_error_next = row_sum - {1'b0, e_maj};
      cur_row_next   = step_coord(e_row, e_rdir);
    end
  end

  assign out_word = {e_col, e_row, e_color, last};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd_pop) begin
      busy <= active && (points_left_next != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) begin
      cur_col     <= cur_col_next;
      cur_row     <= cur_row_next;
      col_error   <= col_error_next;
      row_error   <= row_error_next;
      abs_dcol    <= e_adc;
      abs_drow    <= e_adr;
      major_len   <= e_maj;
      col_dir     <= e_cdir;
      row_dir     <= e_rdir;
      points_left <= points_left_next;
      held_color  <= e_color;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_has_points: assert property (@(posedge clk) disable iff (rst)
    busy |-> (points_left != '0))
    else $error("busy with no points left");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (out_push && last) |=> !busy)
    else $error("line still running after last point");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    out_push |-> (!out_full && !cmd_empty))
    else $error("point pushed without request or room");

  a_step_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (cmd_pop && !is_start && !busy) |-> !out_push)
    else $error("point from step while idle");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/line_point_generator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// line_point_generator_top
// Line rasterizer: start requests latch a line and emit its first point, step
// requests emit the next pixel point along it.
//
//   channel   ports                                          handshake
//   request   op start_x start_y end_x end_y line_color      push / full
//   point     point_x point_y point_color last_point         pop / empty
//
// The engine takes one request per cycle unless the point queue is full.
// A request's point, if any, enters the point queue in the cycle it is taken.
// Reset empties both queues and leaves no line running.
// Request queue and point queue stall each side on its own; a stalled point
// output backs up into the request queue and then raises full.
// ----------------------------------------------------------------------------
module line_point_generator_top #(
  parameter int COORD_BITS = 9
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  op,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  input  wire logic [15:0]           line_color,
  input  wire logic                  pop,
  output logic                       empty,
  output logic [COORD_BITS-1:0]      point_x,
  output logic [COORD_BITS-1:0]      point_y,
  output logic [15:0]                point_color,
  output logic                       last_point
);
  import lpg_pkg::*;

  localparam int CMD_W = 5 * COORD_BITS + 21;
  localparam int PT_W  = 2 * COORD_BITS + 17;

  logic [CMD_W-1:0] in_word;
  logic [CMD_W-1:0] cmd_word;
  logic             cmd_empty;
  logic             cmd_pop;
  logic [PT_W-1:0]  eng_word;
  logic             eng_push;
  logic             pt_full;
  logic [PT_W-1:0]  pt_word;

  lpg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .op         (op),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .line_color (line_color),
    .cmd_word   (in_word)
  );

  lpg_fifo #(.WIDTH(CMD_W), .DEPTH(4)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (in_word),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_word),
    .empty (cmd_empty)
  );

  lpg_engine #(.COORD_BITS(COORD_BITS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_word  (cmd_word),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_word  (eng_word),
    .out_push  (eng_push),
    .out_full  (pt_full)
  );

  lpg_fifo #(.WIDTH(PT_W), .DEPTH(4)) u_pt_q (
    .clk   (clk),
    .rst   (rst),
    .push  (eng_push),
    .wdata (eng_word),
    .full  (pt_full),
    .pop   (pop),
    .rdata (pt_word),
    .empty (empty)
  );

  assign {point_x, point_y, point_color, last_point} = pt_word;

endmodule
`default_nettype wire
